>>> rtl/core/stepper_ramp_pulse_generator_core_macros.svh
// Assertion macros used by the checker file of the ramp pulse generator.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_CORE_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge and held off during reset.
`define SRPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge and held off during reset.
`define SRPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/srpg_pkg.sv
package srpg_pkg;

    localparam int DIST_W   = 12;
    localparam int SPM_W    = 10;
    localparam int LEVELS_W = 8;
    localparam int BASE_W   = 20;
    localparam int DWELL_W  = 24;
    localparam int STEPS_W  = 22;
    localparam int DELAY_W  = 32;
    localparam int PROD_W   = DWELL_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPS_PER_MM = 3'd0,
        CFG_LEVEL_COUNT  = 3'd1,
        CFG_BASE_DELAY   = 3'd2,
        CFG_LEVEL_DWELL  = 3'd3,
        CFG_MOTOR_IN_USE = 3'd4
    } cfg_index_t;

    localparam logic [SPM_W-1:0]    RST_STEPS_PER_MM = 10'd80;
    localparam logic [LEVELS_W-1:0] RST_LEVEL_COUNT  = 8'd10;
    localparam logic [BASE_W-1:0]   RST_BASE_DELAY   = 20'd1000;
    localparam logic [DWELL_W-1:0]  RST_LEVEL_DWELL  = 24'd50000;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [SPM_W-1:0]    steps_per_mm;
        logic [LEVELS_W-1:0] level_count;
        logic [BASE_W-1:0]   base_delay_ticks;
        logic [DWELL_W-1:0]  level_dwell_ticks;
        logic                motor_in_use;
    } cfg_t;

    typedef struct packed {
        logic step_pulse;
        logic direction;
        logic busy_res;
        logic move_done;
    } res_t;

endpackage

>>> rtl/core/srpg_in_if.sv
interface srpg_in_if;
    import srpg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic signed [DIST_W-1:0] distance_mm;

    modport source (output valid, kind, distance_mm, input ready);
    modport sink (input valid, kind, distance_mm, output ready);
endinterface

>>> rtl/core/srpg_out_if.sv
interface srpg_out_if;
    logic valid;
    logic ready;
    logic step_pulse;
    logic direction;
    logic busy_res;
    logic move_done;

    modport source (output valid, step_pulse, direction, busy_res, move_done, input ready);
    modport sink (input valid, step_pulse, direction, busy_res, move_done, output ready);
endinterface

>>> rtl/core/srpg_cfg.sv
module srpg_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output srpg_pkg::cfg_t                     cfg
);
    import srpg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STEPS_PER_MM: cfg_next.steps_per_mm      = cfg_data[SPM_W-1:0];
                CFG_LEVEL_COUNT:  cfg_next.level_count       = cfg_data[LEVELS_W-1:0];
                CFG_BASE_DELAY:   cfg_next.base_delay_ticks  = cfg_data[BASE_W-1:0];
                CFG_LEVEL_DWELL:  cfg_next.level_dwell_ticks = cfg_data[DWELL_W-1:0];
                CFG_MOTOR_IN_USE: cfg_next.motor_in_use      = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_mm      <= RST_STEPS_PER_MM;
            cfg_reg.level_count       <= RST_LEVEL_COUNT;
            cfg_reg.base_delay_ticks  <= RST_BASE_DELAY;
            cfg_reg.level_dwell_ticks <= RST_LEVEL_DWELL;
            cfg_reg.motor_in_use      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

>>> rtl/core/srpg_ramp.sv
module srpg_ramp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  logic                               kind,
    input  logic signed [srpg_pkg::DIST_W-1:0] distance_mm,
    input  srpg_pkg::cfg_t                     cfg,
    output srpg_pkg::res_t                     result
);
    import srpg_pkg::*;

    // The product of steps at the current level and the delay is kept as a running
    // sum that saturates just above the largest dwell, so no multiplier sits in the loop.
    localparam logic [PROD_W-1:0] PROD_SAT = PROD_W'(1) << DWELL_W;

    logic [STEPS_W-1:0] remaining_reg, remaining_next;
    logic               negative_reg, negative_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [DELAY_W-1:0] wait_reg, wait_next;
    logic [STEPS_W-1:0] at_level_reg, at_level_next;
    logic [STEPS_W-1:0] record_reg, record_next;
    logic [STEPS_W-1:0] taken_reg, taken_next;
    logic               moving_reg, moving_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    logic [DIST_W-1:0]         mag;
    logic [STEPS_W-1:0]        start_steps;
    logic [BASE_W+LEVELS_W-1:0] start_delay;
    logic [STEPS_W-1:0]        rem_dec;
    logic [STEPS_W-1:0]        lvl_inc;
    logic [STEPS_W-1:0]        taken_inc;
    logic [PROD_W:0]           prod_sum;
    logic [PROD_W-1:0]         prod_step;
    logic                      dwell_hit;
    logic [DELAY_W:0]          delay_up;
    logic                      pulse;
    logic                      done;

    always_comb
    begin
        mag         = distance_mm[DIST_W-1] ? DIST_W'(-distance_mm) : distance_mm;
        start_steps = STEPS_W'(mag * cfg.steps_per_mm);
        start_delay = cfg.base_delay_ticks * cfg.level_count;

        rem_dec   = remaining_reg - 1'b1;
        lvl_inc   = at_level_reg + 1'b1;
        taken_inc = taken_reg + 1'b1;
        prod_sum  = {1'b0, prod_reg} + {2'b00, delay_reg[DWELL_W-1:0]};
        if ((|delay_reg[DELAY_W-1:DWELL_W]) || (prod_sum >= {1'b0, PROD_SAT}))
        begin
            prod_step = PROD_SAT;
        end
        else
        begin
            prod_step = prod_sum[PROD_W-1:0];
        end
        dwell_hit = prod_step > {1'b0, cfg.level_dwell_ticks};
        delay_up  = {1'b0, delay_reg} + {{(DELAY_W-BASE_W+1){1'b0}}, cfg.base_delay_ticks};

        remaining_next = remaining_reg;
        negative_next  = negative_reg;
        delay_next     = delay_reg;
        wait_next      = wait_reg;
        at_level_next  = at_level_reg;
        record_next    = record_reg;
        taken_next     = taken_reg;
        moving_next    = moving_reg;
        prod_next      = prod_reg;
        pulse          = 1'b0;
        done           = 1'b0;

        if (item_kind_t'(kind) == KIND_START)
        begin
            negative_next = distance_mm[DIST_W-1];
            delay_next    = DELAY_W'(start_delay);
            wait_next     = '0;
            at_level_next = '0;
            record_next   = '0;
            taken_next    = '0;
            prod_next     = '0;
            if (!cfg.motor_in_use || (start_steps == '0))
            begin
                remaining_next = '0;
                moving_next    = 1'b0;
                done           = 1'b1;
            end
            else
            begin
                remaining_next = start_steps;
                moving_next    = 1'b1;
            end
        end
        else if (moving_reg)
        begin
            if (!cfg.motor_in_use)
            begin
                moving_next = 1'b0;
                done        = 1'b1;
            end
            else if (wait_reg == '0)
            begin
                pulse          = 1'b1;
                remaining_next = rem_dec;
                taken_next     = taken_inc;
                at_level_next  = lvl_inc;
                prod_next      = prod_step;
                wait_next      = (delay_reg == '0) ? '0 : delay_reg - 1'b1;
                if (rem_dec > taken_inc)
                begin
                    if (dwell_hit && (delay_reg > DELAY_W'(cfg.base_delay_ticks)))
                    begin
                        delay_next    = delay_reg - DELAY_W'(cfg.base_delay_ticks);
                        record_next   = record_reg + lvl_inc;
                        at_level_next = '0;
                        prod_next     = '0;
                    end
                end
                else if (rem_dec <= record_reg)
                begin
                    if (dwell_hit)
                    begin
                        delay_next    = delay_up[DELAY_W] ? '1 : delay_up[DELAY_W-1:0];
                        at_level_next = '0;
                        prod_next     = '0;
                    end
                end
                if (rem_dec == '0)
                begin
                    moving_next = 1'b0;
                    done        = 1'b1;
                end
            end
            else
            begin
                wait_next = wait_reg - 1'b1;
            end
        end

        result.step_pulse = pulse;
        result.direction  = negative_next;
        result.busy_res   = moving_next;
        result.move_done  = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            negative_reg  <= 1'b0;
            delay_reg     <= '0;
            wait_reg      <= '0;
            at_level_reg  <= '0;
            record_reg    <= '0;
            taken_reg     <= '0;
            moving_reg    <= 1'b0;
            prod_reg      <= '0;
        end
        else if (fire)
        begin
            remaining_reg <= remaining_next;
            negative_reg  <= negative_next;
            delay_reg     <= delay_next;
            wait_reg      <= wait_next;
            at_level_reg  <= at_level_next;
            record_reg    <= record_next;
            taken_reg     <= taken_next;
            moving_reg    <= moving_next;
            prod_reg      <= prod_next;
        end
    end
endmodule

>>> rtl/core/stepper_ramp_pulse_generator_core.sv
// Trapezoidal stepper ramp generator. Each transaction on cmd is either one timer tick or a
// move start with a signed distance in millimetres, and each gives exactly one transaction on
// res through the input register and then the result register. One transaction is taken every
// clock cycle as long as res is drained; the step-timing state is updated on the same edge that
// loads the result register, and the dwell product is kept as a saturating running sum so no
// multiplier sits in that loop. A move starts at base_delay_ticks times the level count, speeds
// up one level at a time, and slows down once the remaining steps fall to the ramp-up count.
// Configuration is written through cfg_we, cfg_index and cfg_data and should only change while
// no move is running and no transaction is in flight.
module stepper_ramp_pulse_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    srpg_in_if.sink                         cmd,
    srpg_out_if.source                      res,
    input  logic                            cfg_we,
    input  logic [srpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srpg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srpg_pkg::*;

    cfg_t cfg;
    res_t result;

    logic                     in_valid_reg, in_valid_next;
    logic                     in_kind_reg;
    logic signed [DIST_W-1:0] in_dist_reg;
    logic                     res_valid_reg, res_valid_next;
    res_t                     res_reg;
    logic                     advance;
    logic                     fire;

    assign advance   = !res_valid_reg || res.ready;
    assign fire      = in_valid_reg && advance;
    assign cmd.ready = advance || !in_valid_reg;

    always_comb
    begin
        in_valid_next  = cmd.ready ? cmd.valid : in_valid_reg;
        res_valid_next = advance ? in_valid_reg : res_valid_reg;
    end

    srpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srpg_ramp u_ramp (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .kind        (in_kind_reg),
        .distance_mm (in_dist_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_kind_reg <= cmd.kind;
            in_dist_reg <= cmd.distance_mm;
        end
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.step_pulse = res_reg.step_pulse;
    assign res.direction  = res_reg.direction;
    assign res.busy_res   = res_reg.busy_res;
    assign res.move_done  = res_reg.move_done;
endmodule

>>> rtl/core/srpg_checker.sv
`include "stepper_ramp_pulse_generator_core_macros.svh"

module srpg_checker (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_ready,
    input logic res_valid,
    input logic res_ready,
    input logic step_pulse,
    input logic direction,
    input logic busy_res,
    input logic move_done
);
    // A stalled result transaction keeps its payload.
    `SRPG_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({step_pulse, direction, busy_res, move_done}), "res payload changed while stalled")

    // Input is never back-pressured while the result side is free.
    `SRPG_ASSERT_NOW(a_cmd_ready_free, !res_valid || res_ready, cmd_ready, "cmd stalled while res is free")

    // A step either leaves the move running or finishes it, never both.
    `SRPG_ASSERT_NOW(a_step_state, res_valid && step_pulse, busy_res != move_done, "step with inconsistent busy and done")

    // A finished move is never reported as busy.
    `SRPG_ASSERT_NOW(a_done_idle, res_valid && move_done, !busy_res, "move_done while busy")
endmodule

bind stepper_ramp_pulse_generator_core srpg_checker u_srpg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .step_pulse (res.step_pulse),
    .direction  (res.direction),
    .busy_res   (res.busy_res),
    .move_done  (res.move_done)
);

>>> sim/stepper_ramp_pulse_generator_core_test.sv
module stepper_ramp_pulse_generator_core_test;
    import srpg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 70;
    localparam int SCRIPT_ROWS = 15;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] SPARE_CFG_IDX = 3'd7;

    typedef struct packed {
        item_kind_t  kind;
        logic [11:0] distance;
        logic        typed;
        res_t        want;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srpg_in_if cmd_ch();
    srpg_out_if res_ch();

    stepper_ramp_pulse_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies seen by the motion predictor.
    logic [SPM_W-1:0]    c_spm;
    logic [LEVELS_W-1:0] c_levels;
    logic [BASE_W-1:0]   c_base;
    logic [DWELL_W-1:0]  c_dwell;
    logic                c_enable;

    // Motion state of the predictor.
    logic [STEPS_W-1:0] m_remaining;
    logic [STEPS_W-1:0] m_at_level;
    logic [STEPS_W-1:0] m_ramp_rec;
    logic [STEPS_W-1:0] m_taken;
    logic [DELAY_W-1:0] m_delay;
    logic [DELAY_W-1:0] m_wait;
    logic               m_neg;
    logic               m_moving;

    res_t pending_results[$];
    bit   idle_draws;
    bit   hold_pending;
    int   n_errors;
    int   n_results;
    int   n_items;
    int   n_starts;
    int   n_pulses;
    int   n_moves_done;
    int   cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("stepper_ramp_pulse_generator_core: mismatch");
                $finish;
            end
        end
    end

    function automatic res_t advance_motion(input item_kind_t k, input logic [11:0] d);
        logic [11:0] mag;
        logic [63:0] prod;
        logic [32:0] raised;
        res_t r;
        r = '0;
        if (k == KIND_START)
        begin
            m_neg = d[11];
            mag = m_neg ? 12'h000 - d : d;
            m_remaining = 22'(mag) * 22'(c_spm);
            m_delay = 32'(c_base) * 32'(c_levels);
            m_wait = '0;
            m_at_level = '0;
            m_ramp_rec = '0;
            m_taken = '0;
            if (!c_enable || m_remaining == '0)
            begin
                m_moving = 1'b0;
                m_remaining = '0;
                r.move_done = 1'b1;
            end
            else
            begin
                m_moving = 1'b1;
            end
        end
        else if (m_moving)
        begin
            if (!c_enable)
            begin
                m_moving = 1'b0;
                r.move_done = 1'b1;
            end
            else if (m_wait == '0)
            begin
                m_remaining = m_remaining - 1'b1;
                m_at_level = m_at_level + 1'b1;
                m_taken = m_taken + 1'b1;
                m_wait = (m_delay != '0) ? m_delay - 1'b1 : '0;
                prod = 64'(m_at_level) * 64'(m_delay);
                if (m_remaining > m_taken)
                begin
                    if (prod > 64'(c_dwell) && m_delay > 32'(c_base))
                    begin
                        m_delay = m_delay - 32'(c_base);
                        m_ramp_rec = m_ramp_rec + m_at_level;
                        m_at_level = '0;
                    end
                end
                else if (m_remaining <= m_ramp_rec)
                begin
                    if (prod > 64'(c_dwell))
                    begin
                        raised = 33'(m_delay) + 33'(c_base);
                        m_delay = raised[32] ? '1 : raised[31:0];
                        m_at_level = '0;
                    end
                end
                r.step_pulse = 1'b1;
                if (m_remaining == '0)
                begin
                    m_moving = 1'b0;
                    r.move_done = 1'b1;
                end
            end
            else
            begin
                m_wait = m_wait - 1'b1;
            end
        end
        r.direction = m_neg;
        r.busy_res = m_moving;
        return r;
    endfunction

    // Directed rows run under the reset register values.
    function automatic script_row_t script_row(input int i);
        case (i)
            0:  return {KIND_TICK,  12'h000, 1'b1, 4'b0000};
            1:  return {KIND_START, 12'h000, 1'b1, 4'b0001};
            2:  return {KIND_START, 12'hFFF, 1'b1, 4'b0110};
            3:  return {KIND_TICK,  12'h000, 1'b1, 4'b1110};
            4:  return {KIND_TICK,  12'hFFF, 1'b1, 4'b0110};
            5:  return {KIND_START, 12'h7FF, 1'b1, 4'b0010};
            6:  return {KIND_TICK,  12'h7FF, 1'b1, 4'b1010};
            7:  return {KIND_START, 12'h800, 1'b1, 4'b0110};
            8:  return {KIND_TICK,  12'h800, 1'b0, 4'b0000};
            9:  return {KIND_TICK,  12'h555, 1'b0, 4'b0000};
            10: return {KIND_START, 12'h001, 1'b1, 4'b0010};
            11: return {KIND_START, 12'h000, 1'b1, 4'b0001};
            12: return {KIND_TICK,  12'hAAA, 1'b1, 4'b0000};
            13: return {KIND_START, 12'h801, 1'b0, 4'b0000};
            default: return {KIND_TICK, 12'h000, 1'b0, 4'b0000};
        endcase
    endfunction

    function automatic cfg_t phase_setting(input int p);
        case (p)
            0: return {10'd1,    8'd4,   20'd2,       24'd6,        1'b1};
            1: return {10'd3,    8'd1,   20'd1,       24'd1,        1'b1};
            2: return {10'd1023, 8'd255, 20'd1048575, 24'd16777215, 1'b1};
            3: return {10'd2,    8'd6,   20'd0,       24'd10,       1'b1};
            4: return {10'd1,    8'd5,   20'd3,       24'd0,        1'b1};
            5: return {10'd1,    8'd3,   20'd2,       24'd4,        1'b0};
            default: return {10'd2, 8'd8, 20'd1,      24'd20,       1'b1};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s got %0d, expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic send_item(input item_kind_t k, input logic [11:0] d, input bit typed,
                             input res_t typed_res);
        int gap;
        res_t model_res;
        gap = idle_draws ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= k;
        cmd_ch.distance_mm <= d;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        model_res = advance_motion(k, d);
        pending_results.push_back(typed ? typed_res : model_res);
        n_items++;
        if (k == KIND_START)
            n_starts++;
    endtask

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_STEPS_PER_MM: c_spm = val[SPM_W-1:0];
            CFG_LEVEL_COUNT:  c_levels = val[LEVELS_W-1:0];
            CFG_BASE_DELAY:   c_base = val[BASE_W-1:0];
            CFG_LEVEL_DWELL:  c_dwell = val[DWELL_W-1:0];
            CFG_MOTOR_IN_USE: c_enable = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(CFG_STEPS_PER_MM, 24'(s.steps_per_mm));
        write_reg(CFG_LEVEL_COUNT, 24'(s.level_count));
        write_reg(CFG_BASE_DELAY, 24'(s.base_delay_ticks));
        write_reg(CFG_LEVEL_DWELL, 24'(s.level_dwell_ticks));
        write_reg(CFG_MOTOR_IN_USE, 24'(s.motor_in_use));
        write_reg(SPARE_CFG_IDX, 24'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Each move is a start followed by a run of ticks; some moves are cut short by the next start.
    task automatic run_moves(input int n_target);
        int sent;
        int ticks;
        int v;
        logic [11:0] d;
        sent = 0;
        while (sent < n_target)
        begin
            v = int'($urandom_range(0, 12)) - 6;
            d = ($urandom_range(0, 4) == 0) ? 12'($urandom) : v[11:0];
            send_item(KIND_START, d, 1'b0, '0);
            sent++;
            ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 40);
            while (ticks > 0 && sent < n_target)
            begin
                send_item(KIND_TICK, 12'($urandom), 1'b0, '0);
                sent++;
                ticks--;
            end
        end
    endtask

    initial
    begin
        int stall;
        res_t got;
        res_t want;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = idle_draws ? $urandom_range(0, 7) : 0;
            if (hold_pending)
            begin
                stall = HOLD_OFF_CYCLES;
                hold_pending = 1'b0;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            got.step_pulse = res_ch.step_pulse;
            got.direction = res_ch.direction;
            got.busy_res = res_ch.busy_res;
            got.move_done = res_ch.move_done;
            if (got.step_pulse === 1'b1)
                n_pulses++;
            if (got.move_done === 1'b1)
                n_moves_done++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("transaction with nothing expected", int'(got), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.step_pulse !== want.step_pulse)
                    report_mismatch("step_pulse", int'(got.step_pulse),
                                    int'(want.step_pulse));
                if (got.direction !== want.direction)
                    report_mismatch("direction", int'(got.direction), int'(want.direction));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
                if (got.move_done !== want.move_done)
                    report_mismatch("move_done", int'(got.move_done), int'(want.move_done));
            end
            n_results++;
        end
    end

    initial
    begin
        int p;
        script_row_t row;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind <= KIND_TICK;
        cmd_ch.distance_mm <= '0;
        idle_draws = 1'b1;
        hold_pending = 1'b0;
        n_errors = 0;
        n_results = 0;
        n_items = 0;
        n_starts = 0;
        n_pulses = 0;
        n_moves_done = 0;
        c_spm = RST_STEPS_PER_MM;
        c_levels = RST_LEVEL_COUNT;
        c_base = RST_BASE_DELAY;
        c_dwell = RST_LEVEL_DWELL;
        c_enable = 1'b1;
        m_remaining = '0;
        m_at_level = '0;
        m_ramp_rec = '0;
        m_taken = '0;
        m_delay = '0;
        m_wait = '0;
        m_neg = 1'b0;
        m_moving = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            row = script_row(i);
            send_item(row.kind, row.distance, row.typed, row.want);
        end

        // Switching the motor off while a move is under way must end it on the next tick.
        wait_for_results();
        write_reg(CFG_MOTOR_IN_USE, 24'd0);
        cfg_we <= 1'b0;
        send_item(KIND_TICK, 12'h000, 1'b0, '0);
        send_item(KIND_TICK, 12'hFFF, 1'b0, '0);
        send_item(KIND_START, 12'h003, 1'b0, '0);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_for_results();
            apply_settings(phase_setting(p));
            idle_draws = (p != 1 && p != 3);
            if (p == 1)
                hold_pending = 1'b1;
            run_moves(PHASE_ITEMS);
        end
        wait_for_results();
        repeat (8) @(posedge clk);

        if (pending_results.size() != 0)
            report_mismatch("transactions never delivered", pending_results.size(), 0);
        $display("%0d transactions sent (%0d move starts), %0d results checked",
                 n_items, n_starts, n_results);
        $display("%0d step pulses and %0d finished moves over %0d register settings",
                 n_pulses, n_moves_done, PHASE_COUNT + 1);
        if (n_errors == 0)
            $display("stepper_ramp_pulse_generator_core: match");
        else
            $display("stepper_ramp_pulse_generator_core: mismatch");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/srpg_pkg.sv
rtl/core/srpg_in_if.sv
rtl/core/srpg_out_if.sv
rtl/core/srpg_cfg.sv
rtl/core/srpg_ramp.sv
rtl/core/stepper_ramp_pulse_generator_core.sv
rtl/core/srpg_checker.sv
sim/stepper_ramp_pulse_generator_core_test.sv
